FILE: hdl/lbpd_pkg.sv
// ----------------------------------------------------------------------------
// lbpd_pkg
// Shared types, constants and decode tables of the LCD bus panel decoder.
// ----------------------------------------------------------------------------
package lbpd_pkg;

	localparam int unsigned ADDR_W    = 8;
	localparam int unsigned SEG_W     = 8;
	localparam int unsigned VOLT_W    = 10;
	localparam int unsigned PCT_W     = 7;
	localparam int unsigned LIMIT_W   = 6;
	localparam int unsigned SUM_W     = 16;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_W     = 10;
	localparam int unsigned IN_TDATA_W  = 24;
	localparam int unsigned OUT_TDATA_W = 48;

	localparam logic [ADDR_W-1:0] ADDR_FIRST = 8'd160;
	localparam logic [ADDR_W-1:0] ADDR_IN_TEN = 8'd161;
	localparam logic [ADDR_W-1:0] ADDR_IN_ONE = 8'd162;
	localparam logic [ADDR_W-1:0] ADDR_OUT_HUN = 8'd163;
	localparam logic [ADDR_W-1:0] ADDR_OUT_TEN = 8'd164;
	localparam logic [ADDR_W-1:0] ADDR_OUT_ONE = 8'd165;
	localparam logic [ADDR_W-1:0] ADDR_LOAD = 8'd166;
	localparam logic [ADDR_W-1:0] ADDR_BATT = 8'd167;
	localparam logic [ADDR_W-1:0] ADDR_LAST = 8'd170;

	localparam logic [4:0] MODE_BATT      = 5'd9;
	localparam logic [4:0] MODE_LOW_DIAG  = 5'd10;
	localparam logic [4:0] MODE_BATT_LOW  = 5'd11;
	localparam logic [4:0] MODE_FAULT     = 5'd13;
	localparam logic [4:0] MODE_FAULT_ALT = 5'd15;

	localparam logic [2:0] OS_NORMAL    = 3'd1;
	localparam logic [2:0] OS_ON_BATT   = 3'd2;
	localparam logic [2:0] OS_LOW_INPUT = 3'd3;
	localparam logic [2:0] OS_OVERLOAD  = 3'd4;

	localparam logic [1:0] BS_NORMAL = 2'd1;
	localparam logic [1:0] BS_LOW    = 2'd2;
	localparam logic [1:0] BS_FAULT  = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_IN_THR   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_THR  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_V_LIMIT  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LD_LIMIT = 2'd3;

	localparam logic [VOLT_W-1:0]  IN_THR_RST   = 10'd140;
	localparam logic [VOLT_W-1:0]  OUT_THR_RST  = 10'd90;
	localparam logic [LIMIT_W-1:0] V_LIMIT_RST  = 6'd20;
	localparam logic [LIMIT_W-1:0] LD_LIMIT_RST = 6'd5;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DEC,
		ST_DIV,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic             start;
		logic [SUM_W-1:0] num;
		logic [5:0]       den;
	} div_req_t;

	function automatic logic [3:0] seg_digit(input logic [SEG_W-1:0] s);
		case (s)
			8'h05: seg_digit = 4'd1;
			8'h5E: seg_digit = 4'd2;
			8'h4F: seg_digit = 4'd3;
			8'h27: seg_digit = 4'd4;
			8'h6B: seg_digit = 4'd5;
			8'h7B: seg_digit = 4'd6;
			8'h45: seg_digit = 4'd7;
			8'h7F: seg_digit = 4'd8;
			8'h6F: seg_digit = 4'd9;
			default: seg_digit = 4'd0;
		endcase
	endfunction

	function automatic logic [PCT_W-1:0] bar_percent(input logic [2:0] b);
		case (b)
			3'd7: bar_percent = 7'd100;
			3'd6: bar_percent = 7'd70;
			3'd4: bar_percent = 7'd40;
			default: bar_percent = 7'd10;
		endcase
	endfunction

endpackage

FILE: hdl/lcd_bus_panel_decoder_core.sv
// ----------------------------------------------------------------------------
// lcd_bus_panel_decoder_core
// Decodes sniffed display-bus words into averaged voltages, load and voted
// status of the panel.
// ----------------------------------------------------------------------------
// Each request on the s_ channel is one bus word; exactly one result request
// leaves on the m_ channel for it, carrying the accepted flag, the held
// averages, the committed status fields and the change events.
// A word is taken only while the sequencer is idle. Words that need no mean
// go from decoding straight to the final step; words that update a
// running average (address 166, and 162 or 165 when the voltage reaches its
// threshold) first wait for the shared serial divider, which produces one
// quotient bit per clock. The next word is taken in the cycle after the
// result is registered.
// The result lands in an output register, so the next word is taken while
// the previous result still waits; if the receiver stalls, the finished
// item waits in the final step and no further word is taken.
// Reset clears the sequence tracker, averages, histories and held results
// and loads the register defaults. Configuration writes are taken at any
// time with cfg_we and are meant for idle periods.
// ----------------------------------------------------------------------------
module lcd_bus_panel_decoder_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// word_ok[0], bus_addr[8:1], seg_data[16:9], zero fill
	input  logic [lbpd_pkg::IN_TDATA_W-1:0]     s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// accepted[0], input_voltage[10:1], output_voltage[20:11],
	// output_load[27:21], diag_low_battery[28], output_status[31:29],
	// battery_status[33:32], battery_capacity[40:34], output_status_event[41],
	// battery_status_event[42], capacity_event[43], zero fill
	output logic [lbpd_pkg::OUT_TDATA_W-1:0]    m_tdata,
	input  logic                                cfg_we,
	input  logic [lbpd_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [lbpd_pkg::CFG_W-1:0]          cfg_data
);

	lbpd_pkg::state_t state_q, state_n;

	logic [9:0] in_thr_q, out_thr_q;
	logic [5:0] v_lim_q, ld_lim_q;

	logic       ok_q;
	logic [7:0] addr_q, data_q;

	logic [7:0] last_addr_q;
	logic [9:0] in_dig_q, out_dig_q;
	logic [15:0] in_sum_q, out_sum_q, ld_sum_q;
	logic [5:0] in_cnt_q, out_cnt_q, ld_cnt_q;
	logic [1:0] cur_q;
	logic [2:0] osh_q [3];
	logic [1:0] bsh_q [3];
	logic [6:0] cph_q [3];
	logic [9:0] h_in_q, h_out_q;
	logic [6:0] h_load_q, h_cap_q;
	logic       h_diag_q;
	logic [2:0] h_os_q;
	logic [1:0] h_bs_q;

	logic       m_valid_q;
	logic [lbpd_pkg::OUT_TDATA_W-1:0] m_data_q;

	logic       acc;
	logic [3:0] digit;
	logic [4:0] mode;
	logic [6:0] bar;
	logic [9:0] in_new, out_new;
	logic       avg_in, avg_out, avg_ld;
	logic [9:0] sample;
	logic [15:0] sum_sel, sum_new;
	logic [5:0] cnt_sel, lim_sel, den;
	logic [6:0] cnt_inc;
	logic       wrap;
	logic [15:0] mean;
	logic [1:0] cur;
	logic [2:0] os_v;
	logic [1:0] bs_v;
	logic       diag_v;
	logic [2:0] osh_n [3];
	logic [1:0] bsh_n [3];
	logic [6:0] cph_n [3];
	logic       vote;
	logic       ev_os, ev_bs, ev_cap;
	logic       out_free, commit;
	lbpd_pkg::div_req_t div_req;
	logic       div_busy;

	lbpd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.busy   (div_busy),
		.quot   (mean)
	);

	always_comb begin
		acc = 1'b0;
		if (ok_q) begin
			if (addr_q == lbpd_pkg::ADDR_FIRST && last_addr_q != 8'd0) begin
				acc = 1'b0;
			end else if (addr_q == lbpd_pkg::ADDR_LAST) begin
				acc = 1'b1;
			end else if (!(addr_q inside {[lbpd_pkg::ADDR_FIRST:lbpd_pkg::ADDR_LAST]}) ||
					(addr_q != lbpd_pkg::ADDR_FIRST &&
					{1'b0, addr_q} != {1'b0, last_addr_q} + 9'd1)) begin
				acc = 1'b0;
			end else begin
				acc = 1'b1;
			end
		end
	end

	always_comb begin
		digit   = lbpd_pkg::seg_digit(data_q);
		mode    = data_q[7:3];
		bar     = lbpd_pkg::bar_percent(data_q[2:0]);
		in_new  = in_dig_q;
		out_new = out_dig_q;
		case (addr_q)
			lbpd_pkg::ADDR_FIRST:   in_new = 10'(digit) * 10'd100;
			lbpd_pkg::ADDR_IN_TEN:  in_new = in_dig_q + 10'(digit) * 10'd10;
			lbpd_pkg::ADDR_IN_ONE:  in_new = in_dig_q + 10'(digit);
			lbpd_pkg::ADDR_OUT_HUN: out_new = 10'(digit) * 10'd100;
			lbpd_pkg::ADDR_OUT_TEN: out_new = out_dig_q + 10'(digit) * 10'd10;
			lbpd_pkg::ADDR_OUT_ONE: out_new = out_dig_q + 10'(digit);
			default: ;
		endcase
		avg_in  = acc && addr_q == lbpd_pkg::ADDR_IN_ONE && in_new >= in_thr_q;
		avg_out = acc && addr_q == lbpd_pkg::ADDR_OUT_ONE && out_new >= out_thr_q;
		avg_ld  = acc && addr_q == lbpd_pkg::ADDR_LOAD;
		if (avg_in) begin
			sample = in_new; sum_sel = in_sum_q; cnt_sel = in_cnt_q; lim_sel = v_lim_q;
		end else if (avg_out) begin
			sample = out_new; sum_sel = out_sum_q; cnt_sel = out_cnt_q; lim_sel = v_lim_q;
		end else begin
			sample = 10'(bar); sum_sel = ld_sum_q; cnt_sel = ld_cnt_q; lim_sel = ld_lim_q;
		end
		sum_new = sum_sel + 16'(sample);
		den     = (cnt_sel == 6'd0) ? 6'd1 : cnt_sel;
		cnt_inc = {1'b0, den} + 7'd1;
		wrap    = cnt_inc > {1'b0, lim_sel};
	end

	always_comb begin
		cur    = (cur_q == 2'd3) ? 2'd0 : cur_q;
		os_v   = lbpd_pkg::OS_NORMAL;
		bs_v   = lbpd_pkg::BS_NORMAL;
		diag_v = 1'b0;
		case (mode)
			lbpd_pkg::MODE_BATT: os_v = lbpd_pkg::OS_ON_BATT;
			lbpd_pkg::MODE_BATT_LOW: begin
				os_v = lbpd_pkg::OS_ON_BATT; bs_v = lbpd_pkg::BS_LOW;
			end
			lbpd_pkg::MODE_FAULT, lbpd_pkg::MODE_FAULT_ALT: begin
				os_v = lbpd_pkg::OS_ON_BATT; bs_v = lbpd_pkg::BS_FAULT;
			end
			lbpd_pkg::MODE_LOW_DIAG: begin
				bs_v = lbpd_pkg::BS_LOW; diag_v = 1'b1;
			end
			default: ;
		endcase
		for (int i = 0; i < 3; i++) begin
			osh_n[i] = osh_q[i];
			bsh_n[i] = bsh_q[i];
			cph_n[i] = cph_q[i];
		end
		if (acc && addr_q == lbpd_pkg::ADDR_LOAD) begin
			osh_n[cur] = os_v;
			bsh_n[cur] = bs_v;
		end
		if (acc && addr_q == lbpd_pkg::ADDR_BATT) begin
			cph_n[cur] = bar;
			if (mode == lbpd_pkg::MODE_BATT_LOW) begin
				if (h_os_q == lbpd_pkg::OS_ON_BATT) begin
					osh_n[cur] = lbpd_pkg::OS_LOW_INPUT;
				end
			end else if (mode inside {lbpd_pkg::MODE_FAULT, lbpd_pkg::MODE_FAULT_ALT}) begin
				osh_n[cur] = lbpd_pkg::OS_OVERLOAD;
			end
		end
		vote   = acc && cur == 2'd2 &&
			(addr_q == lbpd_pkg::ADDR_LOAD || addr_q == lbpd_pkg::ADDR_BATT);
		ev_os  = vote && osh_n[0] == osh_n[1] && osh_n[1] == osh_n[2] && h_os_q != osh_n[2];
		ev_bs  = vote && addr_q == lbpd_pkg::ADDR_LOAD &&
			bsh_n[0] == bsh_n[1] && bsh_n[1] == bsh_n[2] && h_bs_q != bsh_n[2];
		ev_cap = vote && addr_q == lbpd_pkg::ADDR_BATT &&
			cph_n[0] == cph_n[1] && cph_n[1] == cph_n[2] && h_cap_q != cph_n[2];
	end

	assign out_free = !m_valid_q || m_tready;
	assign commit   = state_q == lbpd_pkg::ST_FIN && out_free;

	always_comb begin
		state_n = state_q;
		case (state_q)
			lbpd_pkg::ST_IDLE: if (s_tvalid) state_n = lbpd_pkg::ST_DEC;
			lbpd_pkg::ST_DEC: state_n = (avg_in || avg_out || avg_ld) ?
				lbpd_pkg::ST_DIV : lbpd_pkg::ST_FIN;
			lbpd_pkg::ST_DIV: if (!div_busy) state_n = lbpd_pkg::ST_FIN;
			lbpd_pkg::ST_FIN: if (out_free) state_n = lbpd_pkg::ST_IDLE;
			default: state_n = lbpd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready      = state_q == lbpd_pkg::ST_IDLE;
		div_req.start = state_q == lbpd_pkg::ST_DEC && (avg_in || avg_out || avg_ld);
		div_req.num   = sum_new;
		div_req.den   = den;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lbpd_pkg::ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_thr_q  <= lbpd_pkg::IN_THR_RST;
			out_thr_q <= lbpd_pkg::OUT_THR_RST;
			v_lim_q   <= lbpd_pkg::V_LIMIT_RST;
			ld_lim_q  <= lbpd_pkg::LD_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				lbpd_pkg::REG_IN_THR:   in_thr_q <= cfg_data;
				lbpd_pkg::REG_OUT_THR:  out_thr_q <= cfg_data;
				lbpd_pkg::REG_V_LIMIT:  v_lim_q <= cfg_data[5:0];
				lbpd_pkg::REG_LD_LIMIT: ld_lim_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			ok_q   <= s_tdata[0];
			addr_q <= s_tdata[8:1];
			data_q <= s_tdata[16:9];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_addr_q <= '0;
			in_dig_q    <= '0;
			out_dig_q   <= '0;
			in_sum_q    <= '0;
			out_sum_q   <= '0;
			ld_sum_q    <= '0;
			in_cnt_q    <= 6'd1;
			out_cnt_q   <= 6'd1;
			ld_cnt_q    <= 6'd1;
			cur_q       <= '0;
			for (int i = 0; i < 3; i++) begin
				osh_q[i] <= '0;
				bsh_q[i] <= '0;
				cph_q[i] <= '0;
			end
			h_in_q   <= '0;
			h_out_q  <= '0;
			h_load_q <= '0;
			h_cap_q  <= '0;
			h_diag_q <= 1'b0;
			h_os_q   <= '0;
			h_bs_q   <= '0;
		end else if (commit) begin
			if (ok_q) begin
				last_addr_q <= (acc && addr_q != lbpd_pkg::ADDR_LAST) ? addr_q : 8'd0;
			end
			if (acc) begin
				in_dig_q  <= in_new;
				out_dig_q <= out_new;
				if (avg_in) begin
					in_sum_q <= wrap ? mean : sum_new;
					in_cnt_q <= wrap ? 6'd2 : cnt_inc[5:0];
					h_in_q   <= mean[9:0];
				end else if (addr_q == lbpd_pkg::ADDR_IN_ONE && in_new == 10'd0) begin
					h_in_q <= '0;
				end
				if (avg_out) begin
					out_sum_q <= wrap ? mean : sum_new;
					out_cnt_q <= wrap ? 6'd2 : cnt_inc[5:0];
					h_out_q   <= mean[9:0];
				end else if (addr_q == lbpd_pkg::ADDR_OUT_ONE && out_new == 10'd0) begin
					h_out_q <= '0;
				end
				if (avg_ld) begin
					ld_sum_q <= wrap ? mean : sum_new;
					ld_cnt_q <= wrap ? 6'd2 : cnt_inc[5:0];
					h_load_q <= mean[6:0];
					h_diag_q <= diag_v;
				end
				for (int i = 0; i < 3; i++) begin
					osh_q[i] <= osh_n[i];
					bsh_q[i] <= bsh_n[i];
					cph_q[i] <= cph_n[i];
				end
				if (ev_os) h_os_q <= osh_n[2];
				if (ev_bs) h_bs_q <= bsh_n[2];
				if (ev_cap) h_cap_q <= cph_n[2];
				if (addr_q == lbpd_pkg::ADDR_BATT) begin
					cur_q <= (cur == 2'd2) ? 2'd0 : cur + 2'd1;
				end else begin
					cur_q <= cur;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (commit) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			m_data_q[lbpd_pkg::OUT_TDATA_W-1:44] <= '0;
			m_data_q[0]     <= acc;
			m_data_q[10:1]  <= avg_in ? mean[9:0] :
				(acc && addr_q == lbpd_pkg::ADDR_IN_ONE && in_new == 10'd0) ? 10'd0 : h_in_q;
			m_data_q[20:11] <= avg_out ? mean[9:0] :
				(acc && addr_q == lbpd_pkg::ADDR_OUT_ONE && out_new == 10'd0) ? 10'd0 : h_out_q;
			m_data_q[27:21] <= avg_ld ? mean[6:0] : h_load_q;
			m_data_q[28]    <= avg_ld ? diag_v : h_diag_q;
			m_data_q[31:29] <= ev_os ? osh_n[2] : h_os_q;
			m_data_q[33:32] <= ev_bs ? bsh_n[2] : h_bs_q;
			m_data_q[40:34] <= ev_cap ? cph_n[2] : h_cap_q;
			m_data_q[41]    <= ev_os;
			m_data_q[42]    <= ev_bs;
			m_data_q[43]    <= ev_cap;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule

FILE: hdl/lbpd_div.sv
// ----------------------------------------------------------------------------
// lbpd_div
// Restoring divider, 16-bit dividend by 6-bit divisor, one quotient bit per
// clock.
// ----------------------------------------------------------------------------
module lbpd_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lbpd_pkg::div_req_t          req,
	output logic                        busy,
	output logic [lbpd_pkg::SUM_W-1:0]  quot
);

	logic [lbpd_pkg::SUM_W-1:0] work_q;
	logic [5:0] rem_q;
	logic [5:0] den_q;
	logic [3:0] cnt_q;
	logic       busy_q;
	logic [6:0] rem_sh;
	logic       fits;

	assign rem_sh = {rem_q, work_q[lbpd_pkg::SUM_W-1]};
	assign fits   = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 4'd1;
			if (cnt_q == 4'd15) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			work_q <= req.num;
			rem_q  <= '0;
			den_q  <= req.den;
		end else if (busy_q) begin
			work_q <= {work_q[lbpd_pkg::SUM_W-2:0], fits};
			rem_q  <= fits ? 6'(rem_sh - {1'b0, den_q}) : rem_sh[5:0];
		end
	end

	assign busy = busy_q;
	assign quot = work_q;

endmodule

FILE: hdl/lbpd_checker.sv
// ----------------------------------------------------------------------------
// lbpd_checker
// Port-level checks of the LCD bus panel decoder, bound to the top level.
// ----------------------------------------------------------------------------
module lbpd_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                m_tvalid,
	input logic                                m_tready,
	input logic [lbpd_pkg::OUT_TDATA_W-1:0]    m_tdata
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("Stalled result changed.");

	a_event_acc: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[41] || m_tdata[42] || m_tdata[43]) |-> m_tdata[0])
		else $error("Event on a rejected word.");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[31:29] <= 3'd4 && m_tdata[27:21] <= 7'd100)
		else $error("Status or load out of range.");

	a_cap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[40:34] == 7'd0 || m_tdata[40:34] == 7'd10 ||
			m_tdata[40:34] == 7'd40 || m_tdata[40:34] == 7'd70 ||
			m_tdata[40:34] == 7'd100)
		else $error("Capacity is not a bar value.");

endmodule

bind lcd_bus_panel_decoder_core lbpd_checker u_lbpd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
